[sv/qvr_pkg.sv]
package qvr_pkg;

  // widths of the internal arithmetic
  localparam int PW    = 33;  // norm, scalar term, dot and cross products
  localparam int MW    = 49;  // second-level products
  localparam int NW    = 51;  // numerator
  localparam int RW    = 52;  // divider remainder
  localparam int QW    = 17;  // quotient bits
  localparam int STEPS = QW;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;
  } req_t;

  typedef struct packed {
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic [1:0]         status;
  } rsp_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] quo;
    logic          neg;
    logic          ovf;
  } lane_t;

  typedef struct packed {
    logic            valid;
    logic            zero;
    logic [RW-1:0]   dsh;
    lane_t [2:0]     lane;
  } div_t;

endpackage

[sv/qvr_numer.sv]
module qvr_numer (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  qvr_pkg::req_t in_data,
  output qvr_pkg::div_t seed
);
  import qvr_pkg::*;

  // stage 1: first-level products
  logic               v1;
  logic signed [31:0] p_ww, p_xx, p_yy, p_zz;
  logic signed [31:0] p_xvx, p_yvy, p_zvz;
  logic signed [31:0] p_yvz, p_zvy, p_zvx, p_xvz, p_xvy, p_yvx;
  logic signed [15:0] w1, x1, y1, z1, vx1, vy1, vz1;

  // stage 2: norm, scalar term, dot and cross
  logic                 v2;
  logic [PW-1:0]        norm2;
  logic signed [PW-1:0] s2, d2, cx2, cy2, cz2;
  logic signed [15:0]   w2, x2, y2, z2, vx2, vy2, vz2;
  logic signed [PW:0]   nsum;

  // stage 3: second-level products
  logic                 v3;
  logic [PW-1:0]        norm3;
  logic signed [MW-1:0] a3 [3];
  logic signed [MW-1:0] b3 [3];
  logic signed [MW-1:0] c3 [3];

  // stage 4: numerators
  logic                 v4;
  logic [PW-1:0]        norm4;
  logic signed [NW-1:0] n4 [3];

  // stage 5: rounding offset folded in
  logic                 v5;
  logic                 zero5;
  logic [RW-1:0]        dsh5;
  logic [RW-1:0]        m5 [3];
  logic                 neg5 [3];
  logic signed [RW-1:0] dd;

  assign nsum = (PW+1)'(p_ww) + (PW+1)'(p_xx) + (PW+1)'(p_yy) + (PW+1)'(p_zz);
  assign dd   = RW'(norm4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      seed.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      p_ww  <= in_data.quat_w * in_data.quat_w;
      p_xx  <= in_data.quat_x * in_data.quat_x;
      p_yy  <= in_data.quat_y * in_data.quat_y;
      p_zz  <= in_data.quat_z * in_data.quat_z;
      p_xvx <= in_data.quat_x * in_data.vec_x;
      p_yvy <= in_data.quat_y * in_data.vec_y;
      p_zvz <= in_data.quat_z * in_data.vec_z;
      p_yvz <= in_data.quat_y * in_data.vec_z;
      p_zvy <= in_data.quat_z * in_data.vec_y;
      p_zvx <= in_data.quat_z * in_data.vec_x;
      p_xvz <= in_data.quat_x * in_data.vec_z;
      p_xvy <= in_data.quat_x * in_data.vec_y;
      p_yvx <= in_data.quat_y * in_data.vec_x;
      w1  <= in_data.quat_w;
      x1  <= in_data.quat_x;
      y1  <= in_data.quat_y;
      z1  <= in_data.quat_z;
      vx1 <= in_data.vec_x;
      vy1 <= in_data.vec_y;
      vz1 <= in_data.vec_z;

      v2    <= v1;
      norm2 <= nsum[PW-1:0];
      s2    <= PW'(p_ww) - PW'(p_xx) - PW'(p_yy) - PW'(p_zz);
      d2    <= PW'(p_xvx) + PW'(p_yvy) + PW'(p_zvz);
      cx2   <= PW'(p_yvz) - PW'(p_zvy);
      cy2   <= PW'(p_zvx) - PW'(p_xvz);
      cz2   <= PW'(p_xvy) - PW'(p_yvx);
      w2  <= w1;
      x2  <= x1;
      y2  <= y1;
      z2  <= z1;
      vx2 <= vx1;
      vy2 <= vy1;
      vz2 <= vz1;

      v3    <= v2;
      norm3 <= norm2;
      a3[0] <= s2 * vx2;
      a3[1] <= s2 * vy2;
      a3[2] <= s2 * vz2;
      b3[0] <= d2 * x2;
      b3[1] <= d2 * y2;
      b3[2] <= d2 * z2;
      c3[0] <= w2 * cx2;
      c3[1] <= w2 * cy2;
      c3[2] <= w2 * cz2;

      v4    <= v3;
      norm4 <= norm3;
      for (int i = 0; i < 3; i++) begin
        n4[i] <= NW'(a3[i]) + (NW'(b3[i]) <<< 1) + (NW'(c3[i]) <<< 1);
      end

      // 2|n| + norm, so that the quotient by 2 norm rounds half away
      v5    <= v4;
      zero5 <= (norm4 == '0);
      dsh5  <= RW'(norm4) << QW;
      for (int i = 0; i < 3; i++) begin
        neg5[i] <= n4[i][NW-1];
        if (n4[i][NW-1]) begin
          m5[i] <= dd - (RW'(n4[i]) <<< 1);
        end else begin
          m5[i] <= dd + (RW'(n4[i]) <<< 1);
        end
      end

      // stage 6: quotient range check, divider seed
      seed.valid <= v5;
      seed.zero  <= zero5;
      seed.dsh   <= dsh5;
      for (int i = 0; i < 3; i++) begin
        seed.lane[i].rem <= m5[i];
        seed.lane[i].quo <= '0;
        seed.lane[i].neg <= neg5[i];
        seed.lane[i].ovf <= (m5[i] >= (dsh5 << 1));
      end
    end
  end

endmodule

[sv/qvr_div_step.sv]
module qvr_div_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  qvr_pkg::div_t prev,
  output qvr_pkg::div_t next
);
  import qvr_pkg::*;

  logic [RW-1:0] diff [3];
  logic          take [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      take[i] = (prev.lane[i].rem >= prev.dsh);
      diff[i] = take[i] ? prev.lane[i].rem - prev.dsh : prev.lane[i].rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else if (en) begin
      next.valid <= prev.valid;
      next.zero  <= prev.zero;
      next.dsh   <= prev.dsh;
      for (int i = 0; i < 3; i++) begin
        next.lane[i].rem <= diff[i] << 1;
        next.lane[i].quo <= {prev.lane[i].quo[QW-2:0], take[i]};
        next.lane[i].neg <= prev.lane[i].neg;
        next.lane[i].ovf <= prev.lane[i].ovf;
      end
    end
  end

endmodule

[sv/quaternion_vector_rotate.sv]
// quaternion vector rotation: v' = vector part of q p conj(q) / |q|^2, p = (0, v)
// input channel: in_valid / in_stall / in_data carry one request, a quaternion
//   in signed Q2.14 and a vector in signed Q8.8; taken when valid and not stall
// output channel: out_valid / out_stall / out_data carry the rotated vector in
//   Q8.8, rounded to nearest with ties away from zero, clamped per component,
//   and a status: ok, zero quaternion (vector forced to zero) or saturated
// throughput: one request per cycle unless stalled, no state is kept between requests
// pipeline: six arithmetic stages, a 17-stage restoring divider (one quotient
//   bit per stage, three lanes side by side) and the output register
// stall: the whole pipeline holds while a result waits with out_stall high;
//   in_stall is raised only then; bubbles inside the pipeline are not
//   squeezed out, and nothing is dropped or repeated
// reset: rst (synchronous) clears every stage valid bit; no clearing pass
module quaternion_vector_rotate (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  qvr_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output qvr_pkg::rsp_t out_data
);
  import qvr_pkg::*;

  logic          en;
  div_t          chain [STEPS+1];
  logic [15:0]   rot [3];
  logic          sat [3];
  rsp_t          rsp_next;

  // pipeline advances unless a finished result is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  qvr_numer u_numer (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .seed     (chain[0])
  );

  // one quotient bit per stage, msb first
  for (genvar g = 0; g < STEPS; g++) begin : g_div
    qvr_div_step u_step (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .prev (chain[g]),
      .next (chain[g+1])
    );
  end

  // sign and clamp
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!chain[STEPS].lane[i].neg) begin
        sat[i] = chain[STEPS].lane[i].ovf || (chain[STEPS].lane[i].quo > QW'(32767));
        rot[i] = sat[i] ? 16'h7fff : chain[STEPS].lane[i].quo[15:0];
      end else begin
        sat[i] = chain[STEPS].lane[i].ovf || (chain[STEPS].lane[i].quo > QW'(32768));
        rot[i] = sat[i] ? 16'h8000 : 16'(16'd0 - chain[STEPS].lane[i].quo[15:0]);
      end
    end
    if (chain[STEPS].zero) begin
      rsp_next.rot_x  = '0;
      rsp_next.rot_y  = '0;
      rsp_next.rot_z  = '0;
      rsp_next.status = STATUS_ZERO;
    end else begin
      rsp_next.rot_x  = rot[0];
      rsp_next.rot_y  = rot[1];
      rsp_next.rot_z  = rot[2];
      rsp_next.status = (sat[0] || sat[1] || sat[2]) ? STATUS_SAT : STATUS_OK;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= chain[STEPS].valid;
      out_data  <= rsp_next;
    end
  end

  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("held result changed");

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == STATUS_ZERO |->
      out_data.rot_x == '0 && out_data.rot_y == '0 && out_data.rot_z == '0)
    else $error("zero quaternion with nonzero vector");

  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == STATUS_SAT |->
      out_data.rot_x == 16'h7fff || out_data.rot_x == 16'h8000 ||
      out_data.rot_y == 16'h7fff || out_data.rot_y == 16'h8000 ||
      out_data.rot_z == 16'h7fff || out_data.rot_z == 16'h8000)
    else $error("saturated status without a clamped component");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != 2'd3)
    else $error("undefined status");

endmodule

[tb/quaternion_vector_rotate_tb.sv]
`timescale 1ns / 1ps

module quaternion_vector_rotate_tb;
  import qvr_pkg::*;

  localparam int LATENCY   = 24;
  localparam int MAX_CYCLE = 400000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;

  // rotations still in flight, oldest first
  rsp_t rot_pending[$];
  int   fail_count;
  int   cycle_count;
  // receiver behaviour: random stalls, or a long hold-off when hold_cycles > 0
  int   hold_cycles;
  int   rx_wait;
  bit   rx_idle_off;
  bit   tx_idle_off;

  quaternion_vector_rotate u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // round num / den to nearest, ties away from zero, then clamp to 16 bits
  function automatic logic signed [15:0] round_clamp(longint num, longint den,
                                                     inout bit sat);
    longint mag;
    longint quo;
    mag = (num < 0) ? -num : num;
    quo = (mag + den / 2) / den;
    if (num >= 0) begin
      if (quo > 32767) begin
        sat = 1'b1;
        quo = 32767;
      end
      return 16'(quo);
    end
    if (quo > 32768) begin
      sat = 1'b1;
      quo = 32768;
    end
    return 16'(-quo);
  endfunction

  // v' = ((w^2 - u.u) v + 2 (u.v) u + 2 w (u x v)) / |q|^2
  function automatic rsp_t rotate_vector(req_t r);
    longint w, x, y, z, vx, vy, vz;
    longint nrm, s, d, cx, cy, cz;
    bit     sat;
    rsp_t   res;
    w  = r.quat_w;
    x  = r.quat_x;
    y  = r.quat_y;
    z  = r.quat_z;
    vx = r.vec_x;
    vy = r.vec_y;
    vz = r.vec_z;
    nrm = w * w + x * x + y * y + z * z;
    sat = 1'b0;
    if (nrm == 0) begin
      res.rot_x  = '0;
      res.rot_y  = '0;
      res.rot_z  = '0;
      res.status = STATUS_ZERO;
      return res;
    end
    s  = w * w - x * x - y * y - z * z;
    d  = x * vx + y * vy + z * vz;
    cx = y * vz - z * vy;
    cy = z * vx - x * vz;
    cz = x * vy - y * vx;
    res.rot_x  = round_clamp(s * vx + 2 * d * x + 2 * w * cx, nrm, sat);
    res.rot_y  = round_clamp(s * vy + 2 * d * y + 2 * w * cy, nrm, sat);
    res.rot_z  = round_clamp(s * vz + 2 * d * z + 2 * w * cz, nrm, sat);
    res.status = sat ? STATUS_SAT : STATUS_OK;
    return res;
  endfunction

  // offer one request after a random gap, hold it until accepted
  task automatic send_request(req_t r);
    int gap;
    gap = tx_idle_off ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rot_pending.push_back(rotate_vector(r));
  endtask

  function automatic req_t rand_request();
    req_t r;
    r = req_t'({$urandom, $urandom, $urandom, $urandom});
    return r;
  endfunction

  // quaternion components in [-16384, 16383], small vector in [-4096, 4095], the usual case
  function automatic req_t unit_ish_request();
    req_t r;
    r = rand_request();
    r.quat_w = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
    r.quat_x = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
    r.quat_y = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
    r.quat_z = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
    r.vec_x  = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
    r.vec_y  = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
    r.vec_z  = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
    return r;
  endfunction

  // receiver: random wait after each result, or a long hold-off on request
  always @(posedge clk) begin
    int pause;
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
    end else if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (rx_idle_off) begin
      out_stall <= 1'b0;
    end else if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait   <= rx_wait - 1;
    end else if (out_valid && !out_stall) begin
      pause = $urandom_range(0, 8);
      out_stall <= (pause != 0);
      rx_wait   <= (pause != 0) ? pause - 1 : 0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker against the oldest pending rotation
  always @(posedge clk) begin
    rsp_t exp_rot;
    if (!rst && out_valid && !out_stall) begin
      if (rot_pending.size() == 0) begin
        $error("unexpected result %p", out_data);
        fail_count++;
      end else begin
        exp_rot = rot_pending.pop_front();
        if (out_data.rot_x !== exp_rot.rot_x) begin
          $error("rot_x expected %0d actual %0d", exp_rot.rot_x, out_data.rot_x);
          fail_count++;
        end
        if (out_data.rot_y !== exp_rot.rot_y) begin
          $error("rot_y expected %0d actual %0d", exp_rot.rot_y, out_data.rot_y);
          fail_count++;
        end
        if (out_data.rot_z !== exp_rot.rot_z) begin
          $error("rot_z expected %0d actual %0d", exp_rot.rot_z, out_data.rot_z);
          fail_count++;
        end
        if (out_data.status !== exp_rot.status) begin
          $error("status expected %0d actual %0d", exp_rot.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("tb: failure");
      $finish;
    end
  end

  // drop valid, then wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rot_pending.size() != 0) @(posedge clk);
  endtask

  // field extremes, zero quaternion, identity and saturation
  task automatic test_directed();
    req_t r;
    logic signed [15:0] ext[4];
    ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
    r = '0;
    send_request(r);                     // zero quaternion, zero vector
    r.vec_x = 16'sh7fff; r.vec_y = 16'sh8000; r.vec_z = 16'sh1234;
    send_request(r);                     // zero quaternion, nonzero vector
    r.quat_w = 16'sh4000;
    send_request(r);                     // identity
    r.quat_w = 16'sh0001;
    send_request(r);                     // tiny norm
    r = '0; r.quat_x = 16'sh8000; r.vec_x = 16'sh8000; r.vec_y = 16'sh7fff;
    send_request(r);                     // 180 deg about x
    r = '0; r.quat_w = 16'sh0001; r.quat_x = 16'sh0001; r.vec_y = 16'sh0001;
    send_request(r);                     // exact quotient, no rounding needed
    r.vec_y = 16'shffff;
    send_request(r);                     // exact negative quotient
    r = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
    send_request(r);                     // vector on the rotation axis, comes out unchanged
    r = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    send_request(r);
    r = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
    send_request(r);
    for (int i = 0; i < 12; i++) begin
      r.quat_w = ext[$urandom_range(0, 3)];
      r.quat_x = ext[$urandom_range(0, 3)];
      r.quat_y = ext[$urandom_range(0, 3)];
      r.quat_z = ext[$urandom_range(0, 3)];
      r.vec_x  = ext[$urandom_range(0, 3)];
      r.vec_y  = ext[$urandom_range(0, 3)];
      r.vec_z  = ext[$urandom_range(0, 3)];
      send_request(r);
    end
  endtask

  // mostly realistic rotations, some full-range noise and zero quaternions
  task automatic test_random(int count);
    req_t r;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1:    r = rand_request();
        2: begin
          r = rand_request();
          r.quat_w = '0; r.quat_x = '0; r.quat_y = '0; r.quat_z = '0;
        end
        default: r = unit_ish_request();
      endcase
      if (i % 200 == 100) begin
        tx_idle_off = 1'b1;
        rx_idle_off = 1'b1;
      end else if (i % 200 == 140) begin
        tx_idle_off = 1'b0;
        rx_idle_off = 1'b0;
      end
      send_request(r);
    end
  endtask

  // hold the output long enough to fill the pipe and push back on the input
  task automatic test_backpressure();
    tx_idle_off = 1'b1;
    hold_cycles = 80;
    for (int i = 0; i < 60; i++) send_request(unit_ish_request());
    tx_idle_off = 1'b0;
    wait_drained();                      // sender pauses until all results are in
    for (int i = 0; i < 20; i++) send_request(rand_request());
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    fail_count  = 0;
    cycle_count = 0;
    hold_cycles = 0;
    rx_idle_off = 1'b0;
    tx_idle_off = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(950);
    wait_drained();
    repeat (LATENCY * 2) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
